[rtl/core/gf4k_pkg.sv]
// gf4k_pkg: shared types and constants for the gf(2^12) field unit
// no dependencies; imported by every module in rtl/core

package gf4k_pkg;

    localparam int unsigned FIELD_W   = 12;
    localparam int unsigned POLY_W    = FIELD_W + 1;
    localparam int unsigned PROD_W    = 2 * FIELD_W - 1;
    localparam int unsigned DELTA_W   = 6;
    localparam int unsigned INV_STEPS = 2 * FIELD_W - 1;

    // bit-reversed modulus x^12 + x^3 + 1
    localparam logic [POLY_W-1:0] MODULUS_REV = 13'h1009;
    localparam logic [POLY_W-1:0] R_INIT      = 13'h1000;

    typedef enum logic [1:0] {
        CMD_MUL = 2'd0,
        CMD_SQR = 2'd1,
        CMD_INV = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    // everything one divstep cell holds for one beat
    typedef struct packed {
        t_cmd                       cmd;
        logic [FIELD_W-1:0]         a;
        logic [FIELD_W-1:0]         b;
        logic [POLY_W-1:0]          f;
        logic [POLY_W-1:0]          g;
        logic [POLY_W-1:0]          r;
        logic [POLY_W-1:0]          v;
        logic signed [DELTA_W-1:0]  delta;
    } t_cell_state;

endpackage

[rtl/core/gf4k_divstep_cell.sv]
// gf4k_divstep_cell: one registered divstep of the constant-time inverse
// depends on gf4k_pkg

module gf4k_divstep_cell
    import gf4k_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cell_state i_state,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cell_state o_state
);

    logic        r_valid;
    t_cell_state r_state;
    t_cell_state n_state;
    logic        take;
    logic        g0;
    logic        sw;
    logic [POLY_W-1:0] g_x;
    logic [POLY_W-1:0] r_x;
    logic [POLY_W-1:0] v_x;

    assign take = !r_valid || i_ready;

    always_comb begin
        g0  = i_state.g[POLY_W-1];
        sw  = g0 && !i_state.delta[DELTA_W-1] && (i_state.delta != '0);
        g_x = g0 ? (i_state.g ^ i_state.f) : i_state.g;
        r_x = g0 ? (i_state.r ^ i_state.v) : i_state.r;
        v_x = sw ? i_state.r : i_state.v;

        n_state       = i_state;
        n_state.delta = sw ? (DELTA_W'(1) - i_state.delta) : (i_state.delta + DELTA_W'(1));
        n_state.f     = sw ? i_state.g : i_state.f;
        n_state.g     = {g_x[POLY_W-2:0], 1'b0};
        n_state.r     = r_x;
        n_state.v     = v_x >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_ready = take;
    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

[rtl/core/gf4k_mul_stage.sv]
// gf4k_mul_stage: carry-less multiply and modular fold, registered result
// depends on gf4k_pkg

module gf4k_mul_stage
    import gf4k_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_cell_state        i_state,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FIELD_W-1:0] o_result
);

    logic               r_valid;
    logic [FIELD_W-1:0] r_result;
    logic [FIELD_W-1:0] n_result;
    logic [FIELD_W-1:0] mul_x;
    logic [FIELD_W-1:0] mul_y;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  t1;
    logic [PROD_W-1:0]  x1;
    logic [PROD_W-1:0]  t2;
    logic [PROD_W-1:0]  x2;
    logic               take;

    assign take = !r_valid || i_ready;

    // operand select: inverse feeds the multiplier for invert and divide
    always_comb begin
        mul_x = i_state.cmd[1] ? i_state.v[FIELD_W-1:0] : i_state.a;
        case (i_state.cmd)
            CMD_MUL: mul_y = i_state.b;
            CMD_SQR: mul_y = i_state.a;
            CMD_INV: mul_y = FIELD_W'(1);
            CMD_DIV: mul_y = i_state.b;
            default: mul_y = i_state.b;
        endcase
    end

    always_comb begin
        prod = '0;
        for (int k = 0; k < FIELD_W; k++) begin
            if (mul_y[k]) begin
                prod = prod ^ (PROD_W'(mul_x) << k);
            end
        end
        // two-pass fold by x^12 = x^3 + 1
        t1 = prod & PROD_W'(23'h7FC000);
        x1 = prod ^ (t1 >> 9) ^ (t1 >> 12);
        t2 = x1 & PROD_W'(23'h003000);
        x2 = x1 ^ (t2 >> 9) ^ (t2 >> 12);
        n_result = x2[FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_ready  = take;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/core/gf4096_field_alu_unit.sv]
// gf4096_field_alu_unit: top level of the gf(2^12) field unit
// depends on gf4k_pkg, gf4k_divstep_cell and gf4k_mul_stage
//
// usage:
//   input channel  i_in_valid / o_in_ready carries i_cmd, i_operand_a, i_operand_b
//     cmd: multiply a*b, square a, invert a, divide b by a (modulus x^12+x^3+1)
//   output channel o_out_valid / i_out_ready carries o_result, one beat per input beat
//   path: 23 divstep cells, then one multiply-and-fold stage; every command
//     takes the same path, so results leave in input order
//   throughput: one beat per cycle while the receiver does not stall; each
//     cell holds one beat and hands it to its neighbor when that neighbor is
//     ready, the rate is set by the per-cell handshake
//   inverting zero gives zero, so dividing by zero gives zero
//   reset (i_rst_n low, synchronous) empties every cell; no clearing pass
//   when the receiver stalls, the result holds in the output register and
//   the cells behind it keep filling until each holds a beat; o_in_ready
//   drops only once the whole chain is full

module gf4096_field_alu_unit
    import gf4k_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [FIELD_W-1:0] i_operand_a,
    input  logic [FIELD_W-1:0] i_operand_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FIELD_W-1:0] o_result
);

    // chain links: index k feeds cell k, index INV_STEPS feeds the multiplier
    t_cell_state chain_state [INV_STEPS+1];
    logic        chain_valid [INV_STEPS+1];
    logic        chain_ready [INV_STEPS+1];

    // divstep start: f = reversed modulus, g = a shifted up, r = 1, v = 0
    always_comb begin
        chain_state[0].cmd   = t_cmd'(i_cmd);
        chain_state[0].a     = i_operand_a;
        chain_state[0].b     = i_operand_b;
        chain_state[0].f     = MODULUS_REV;
        chain_state[0].g     = {i_operand_a, 1'b0};
        chain_state[0].r     = R_INIT;
        chain_state[0].v     = '0;
        chain_state[0].delta = DELTA_W'(1);
    end

    assign chain_valid[0] = i_in_valid;
    assign o_in_ready     = chain_ready[0];

    for (genvar k = 0; k < INV_STEPS; k++) begin : g_cell
        gf4k_divstep_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_state (chain_state[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_state (chain_state[k+1])
        );
    end

    // product and fold; inverse comes out of the last cell in v
    gf4k_mul_stage u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid[INV_STEPS]),
        .o_ready  (chain_ready[INV_STEPS]),
        .i_state  (chain_state[INV_STEPS]),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // an empty output register lets the whole chain move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output register empty");

    // a stalled first cell keeps its beat
    a_cell_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_valid[1] && !chain_ready[1] |=> chain_valid[1] && $stable(chain_state[1]))
        else $error("first divstep cell lost its beat under stall");

    // delta stays within -23..24 after the last step
    a_delta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_valid[INV_STEPS] |->
            (chain_state[INV_STEPS].delta <= 6'sd24) &&
            (chain_state[INV_STEPS].delta >= -6'sd23))
        else $error("divstep delta out of range");

    // an empty chain after reset gives no output
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
